>>> sv/p25fs_pkg.sv
// Shared types and constants for the P25 frame sync and network ID block.
package p25fs_pkg;

    localparam int SYNC_W     = 48;
    localparam int NID_W      = 64;
    localparam int LIMIT_W    = 6;
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT  = 1'b1;

    localparam logic [SYNC_W-1:0]  SYNC_PATTERN_RESET = 48'h5575_F5FF_77FF;
    localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RESET  = 6'd4;

    localparam logic signed [SAMPLE_W-1:0] SLICE_HIGH = 16'sd8192;
    localparam logic signed [SAMPLE_W-1:0] SLICE_LOW  = -16'sd8192;

    localparam logic [INDEX_W-1:0] NID_START    = 6'd24;
    localparam logic [INDEX_W-1:0] STATUS_INDEX = 6'd36;
    localparam logic [INDEX_W-1:0] NID_LAST     = 6'd56;

    typedef logic [1:0] dibit_t;

    localparam dibit_t DIBIT_POS_LOW  = 2'd0;
    localparam dibit_t DIBIT_POS_HIGH = 2'd1;
    localparam dibit_t DIBIT_NEG_LOW  = 2'd2;
    localparam dibit_t DIBIT_NEG_HIGH = 2'd3;

    typedef struct packed {
        logic [SYNC_W-1:0]  sync_pattern;
        logic [LIMIT_W-1:0] error_limit;
    } cfg_t;

    typedef struct packed {
        logic   empty;
        dibit_t dibit;
    } fifo_head_t;

endpackage

>>> sv/p25fs_sample_if.sv
// Input channel carrying one demodulated sample per transfer.
interface p25fs_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

>>> sv/p25fs_result_if.sv
// Output channel carrying one sync word and network ID per transfer.
interface p25fs_result_if;
    logic        valid;
    logic        ready;
    logic [47:0] sync_word;
    logic [63:0] nid_word;

    modport source (output valid, output sync_word, output nid_word, input ready);
    modport sink (input valid, input sync_word, input nid_word, output ready);
endinterface

>>> sv/p25fs_slicer.sv
// Front end: accepts samples and slices each one into a dibit.
module p25fs_slicer (
    p25fs_sample_if.sink   samples,
    input  logic           fifo_full,
    output logic           push,
    output p25fs_pkg::dibit_t push_dibit
);
    import p25fs_pkg::*;

    assign samples.ready = !fifo_full;
    assign push          = samples.valid && !fifo_full;

    always_comb
    begin
        if (samples.sample < SLICE_LOW)
        begin
            push_dibit = DIBIT_NEG_HIGH;
        end
        else if (samples.sample < 16'sd0)
        begin
            push_dibit = DIBIT_NEG_LOW;
        end
        else if (samples.sample < SLICE_HIGH)
        begin
            push_dibit = DIBIT_POS_LOW;
        end
        else
        begin
            push_dibit = DIBIT_POS_HIGH;
        end
    end

endmodule

>>> sv/p25fs_dibit_fifo.sv
// Short dibit queue between the slicer and the sync tracker.
module p25fs_dibit_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  p25fs_pkg::dibit_t      push_dibit,
    output logic                   full,
    input  logic                   pop,
    output p25fs_pkg::fifo_head_t  head
);
    import p25fs_pkg::*;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    dibit_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full       = (count_reg == COUNT_W'(DEPTH));
    assign head.empty = (count_reg == '0);
    assign head.dibit = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_dibit;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Dibit queue written while full.");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !head.empty)
        else $error("Dibit queue read while empty.");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= COUNT_W'(DEPTH))
        else $error("Dibit queue count above its depth.");

endmodule

>>> sv/p25fs_tracker.sv
// Back end: sync correlation, network ID capture and the result register.
module p25fs_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  p25fs_pkg::cfg_t       cfg,
    input  p25fs_pkg::fifo_head_t head,
    output logic                  pop,
    p25fs_result_if.source        results
);
    import p25fs_pkg::*;

    logic               locked_reg;
    logic               locked_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic [SYNC_W-1:0]  sync_shift_reg;
    logic [SYNC_W-1:0]  sync_shift_next;
    logic [NID_W-1:0]   nid_shift_reg;
    logic [NID_W-1:0]   nid_shift_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SYNC_W-1:0]  out_sync_reg;
    logic [SYNC_W-1:0]  out_sync_next;
    logic [NID_W-1:0]   out_nid_reg;
    logic [NID_W-1:0]   out_nid_next;
    logic [SYNC_W-1:0]  sync_cand;
    logic [NID_W-1:0]   nid_cand;
    logic [LIMIT_W-1:0] errors;
    logic               emit;

    assign pop       = !head.empty && (!out_valid_reg || results.ready);
    assign sync_cand = {sync_shift_reg[SYNC_W-3:0], head.dibit};
    assign nid_cand  = {nid_shift_reg[NID_W-3:0], head.dibit};
    assign errors    = LIMIT_W'($countones(sync_cand ^ cfg.sync_pattern));
    assign emit      = pop && locked_reg && (index_reg == NID_LAST);

    always_comb
    begin
        locked_next     = locked_reg;
        index_next      = index_reg;
        sync_shift_next = sync_shift_reg;
        nid_shift_next  = nid_shift_reg;
        if (pop)
        begin
            if (!locked_reg)
            begin
                sync_shift_next = sync_cand;
                if (errors < cfg.error_limit)
                begin
                    locked_next = 1'b1;
                    index_next  = NID_START;
                end
            end
            else
            begin
                if (index_reg != STATUS_INDEX)
                begin
                    nid_shift_next = nid_cand;
                end
                if (index_reg == NID_LAST)
                begin
                    locked_next = 1'b0;
                end
                index_next = index_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_sync_next  = out_sync_reg;
        out_nid_next   = out_nid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_sync_next  = sync_shift_reg;
            out_nid_next   = nid_cand;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg     <= 1'b0;
            index_reg      <= '0;
            sync_shift_reg <= '0;
            nid_shift_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            locked_reg     <= locked_next;
            index_reg      <= index_next;
            sync_shift_reg <= sync_shift_next;
            nid_shift_reg  <= nid_shift_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sync_reg <= out_sync_next;
        out_nid_reg  <= out_nid_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.sync_word = out_sync_reg;
    assign results.nid_word  = out_nid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> (index_reg >= NID_START) && (index_reg <= NID_LAST))
        else $error("Symbol index outside the network ID window while locked.");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(locked_reg) && ($past(index_reg) == NID_LAST))
        else $error("Result raised without completing a network ID.");
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !locked_reg)
        else $error("Tracker stayed locked after a result.");

endmodule

>>> sv/p25_frame_sync_nid_extractor.sv
// Top level of the P25 frame sync correlator and network ID capture block.
//
// The samples channel takes one signed Q4.12 symbol value per transfer. Each
// sample is sliced to a dibit and placed in a short queue. The tracker reads one
// dibit per cycle while one is queued and the result register is free or being
// read, hunts for the 48-bit sync pattern, and after sync collects the 32
// network ID dibits, dropping the status symbol in between. The results channel
// gives one transfer per captured frame: the matched sync word and the 64
// network ID bits. Throughput is one sample per cycle while the receiver keeps
// up, set by the combinational slice and popcount and the dibit shift in the
// tracker. The last network ID sample waits in the queue behind any dibit ahead
// of it, and its result is then registered. Reset clears the queue, the tracker
// and the result valid flag, and loads the default sync pattern and error limit.
// Configuration writes take effect at once; the user must make them only while
// the block is idle, which the block does not enforce. When the receiver stalls,
// the result register holds its transfer and the tracker stops reading; the
// queue then fills and samples.ready falls.
module p25_frame_sync_nid_extractor #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [p25fs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [p25fs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    p25fs_sample_if.sink                         samples,
    p25fs_result_if.source                       results
);
    import p25fs_pkg::*;

    logic [SYNC_W-1:0]  sync_pattern_reg;
    logic [SYNC_W-1:0]  sync_pattern_next;
    logic [LIMIT_W-1:0] error_limit_reg;
    logic [LIMIT_W-1:0] error_limit_next;
    cfg_t               cfg;
    logic               fifo_full;
    logic               push;
    dibit_t             push_dibit;
    logic               pop;
    fifo_head_t         head;

    always_comb
    begin
        sync_pattern_next = sync_pattern_reg;
        error_limit_next  = error_limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_PATTERN: sync_pattern_next = cfg_wdata[SYNC_W-1:0];
                REG_ERROR_LIMIT:  error_limit_next  = cfg_wdata[LIMIT_W-1:0];
                default:          sync_pattern_next = sync_pattern_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= SYNC_PATTERN_RESET;
            error_limit_reg  <= ERROR_LIMIT_RESET;
        end
        else
        begin
            sync_pattern_reg <= sync_pattern_next;
            error_limit_reg  <= error_limit_next;
        end
    end

    assign cfg.sync_pattern = sync_pattern_reg;
    assign cfg.error_limit  = error_limit_reg;

    p25fs_slicer u_slicer (
        .samples    (samples),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_dibit (push_dibit)
    );

    p25fs_dibit_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_dibit (push_dibit),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head)
    );

    p25fs_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule
